[src/orec_pkg.sv]
package orec_pkg;

    localparam int CFG_W = 5;
    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FETCH,
        ST_CHECK,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic clear;
        logic fill;
        logic evict;
        logic scan_start;
        logic scan_upd;
    } t_slot_ctl;

endpackage

[src/orec_store.sv]
module orec_store #(
    parameter int MAX_REQUESTS = 128,
    parameter int ID_BITS      = 8
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [$clog2(MAX_REQUESTS)-1:0] i_wr_addr,
    input  logic [ID_BITS-1:0]              i_wr_data,
    input  logic [$clog2(MAX_REQUESTS)-1:0] i_rd_addr,
    output logic [ID_BITS-1:0]              o_rd_data
);
    import orec_pkg::*;

    logic [ID_BITS-1:0] r_mem [MAX_REQUESTS];
    logic [ID_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/orec_slots.sv]
module orec_slots #(
    parameter int MAX_SLOTS = 16,
    parameter int ID_BITS   = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  orec_pkg::t_slot_ctl              i_ctl,
    input  logic [$clog2(MAX_SLOTS+1)-1:0]   i_cap,
    input  logic [ID_BITS-1:0]               i_id,
    input  logic [ID_BITS-1:0]               i_scan_id,
    output logic                             o_hit,
    output logic                             o_full,
    output logic                             o_scan_done
);
    import orec_pkg::*;

    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int XW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [ID_BITS-1:0]   r_slot [MAX_SLOTS];
    logic [SW-1:0]        r_filled;
    logic [MAX_SLOTS-1:0] r_found;

    logic [MAX_SLOTS-1:0] w_valid;
    logic [MAX_SLOTS-1:0] w_match_cur;
    logic [MAX_SLOTS-1:0] w_match_scan;
    logic [MAX_SLOTS-1:0] w_found_nx;
    logic [XW-1:0]        w_match_idx;
    logic [XW-1:0]        w_low_idx;
    logic [XW-1:0]        w_victim;

    always_comb begin
        w_match_idx = '0;
        w_low_idx   = '0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            w_valid[s]      = SW'(s) < r_filled;
            w_match_cur[s]  = w_valid[s] && (r_slot[s] == i_id);
            w_match_scan[s] = w_valid[s] && (r_slot[s] == i_scan_id);
            if (w_match_scan[s]) begin
                w_match_idx = w_match_idx | XW'(s);
            end
        end
        // lowest resident slot with no later use
        for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
            if (w_valid[s] && !r_found[s]) begin
                w_low_idx = XW'(s);
            end
        end
        w_found_nx  = r_found | w_match_scan;
        o_scan_done = i_ctl.scan_upd && (|w_match_scan) && (&(w_found_nx | ~w_valid));
        w_victim    = o_scan_done ? w_match_idx : w_low_idx;
        o_hit       = |w_match_cur;
        o_full      = r_filled >= i_cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_found  <= '0;
        end else begin
            if (i_ctl.clear) begin
                r_filled <= '0;
            end else if (i_ctl.fill) begin
                r_filled <= r_filled + SW'(1);
            end
            if (i_ctl.scan_start) begin
                r_found <= '0;
            end else if (i_ctl.scan_upd) begin
                r_found <= w_found_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill) begin
            r_slot[r_filled[XW-1:0]] <= i_id;
        end else if (i_ctl.evict) begin
            r_slot[w_victim] <= i_id;
        end
    end

endmodule

[src/optimal_replacement_eviction_counter.sv]
// Optimal (farthest-next-use) replacement eviction counter.
// Requests come in as command words: a word is taken at a rising edge with
// start high and busy low. Each accepted word is written into the request
// store in that cycle, so a sequence loads at one word per cycle; words past
// MAX_REQUESTS are dropped. A word with i_last_request set starts the replay
// of the stored sequence and busy stays high until it ends.
// Replay handles each stored request with a store read, then a hit/fill check.
// An eviction adds a forward scan of the store, one stored word at a time
// from the next request, until every resident item has been seen again or
// the end of the sequence is reached. The single store read port sets this pace.
// The result, o_eviction_count, appears for one cycle with o_valid in the
// cycle busy drops; the receiver must take it then, there is no back-pressure.
// i_cfg_wr_en / i_cfg_wr_data set the slot count (0 acts as 1, values above
// MAX_SLOTS act as MAX_SLOTS); write it only while busy is low.
// Reset clears the sequence, the slots and the counter and sets the slot
// count to 1; the block is ready in the first cycle after reset.
module optimal_replacement_eviction_counter #(
    parameter int MAX_REQUESTS = 128,
    parameter int MAX_SLOTS    = 16,
    parameter int ID_BITS      = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [orec_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                       start,
    output logic                       busy,
    input  logic [ID_BITS-1:0]         i_request_id,
    input  logic                       i_last_request,
    output logic                       o_valid,
    output logic [orec_pkg::CNT_W-1:0] o_eviction_count
);
    import orec_pkg::*;

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int AW = $clog2(MAX_REQUESTS);
    localparam int SW = $clog2(MAX_SLOTS + 1);

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [CW-1:0]      r_total, n_total;
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic               r_scan_vld, n_scan_vld;
    logic [ID_BITS-1:0] r_cur_id, n_cur_id;
    logic [CNT_W-1:0]   r_evict, n_evict;
    logic               r_out_vld, n_out_vld;
    logic [CNT_W-1:0]   r_out_cnt, n_out_cnt;

    logic [SW-1:0]      w_cap;
    logic               w_store_we;
    logic [AW-1:0]      w_rd_addr;
    logic [ID_BITS-1:0] w_rd_data;
    logic [ID_BITS-1:0] w_slot_id;
    logic               w_step_done;
    t_slot_ctl          w_ctl;
    logic               w_hit;
    logic               w_full;
    logic               w_scan_done;

    always_comb begin
        if (r_cfg == '0) begin
            w_cap = SW'(1);
        end else if (int'(r_cfg) > MAX_SLOTS) begin
            w_cap = SW'(MAX_SLOTS);
        end else begin
            w_cap = SW'(r_cfg);
        end
    end

    orec_store #(
        .MAX_REQUESTS(MAX_REQUESTS),
        .ID_BITS     (ID_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (w_store_we),
        .i_wr_addr(r_total[AW-1:0]),
        .i_wr_data(i_request_id),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_rd_addr = (r_state == ST_FETCH) ? r_i[AW-1:0] : r_j[AW-1:0];
    assign w_slot_id = (r_state == ST_CHECK) ? w_rd_data : r_cur_id;

    orec_slots #(
        .MAX_SLOTS(MAX_SLOTS),
        .ID_BITS  (ID_BITS)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_cap      (w_cap),
        .i_id       (w_slot_id),
        .i_scan_id  (w_rd_data),
        .o_hit      (w_hit),
        .o_full     (w_full),
        .o_scan_done(w_scan_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_cfg      <= CFG_W'(1);
            r_total    <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_scan_vld <= 1'b0;
            r_evict    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            r_total    <= n_total;
            r_i        <= n_i;
            r_j        <= n_j;
            r_scan_vld <= n_scan_vld;
            r_evict    <= n_evict;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_id  <= n_cur_id;
        r_out_cnt <= n_out_cnt;
    end

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_i         = r_i;
        n_j         = r_j;
        n_scan_vld  = r_scan_vld;
        n_cur_id    = r_cur_id;
        n_evict     = r_evict;
        n_out_vld   = 1'b0;
        n_out_cnt   = r_out_cnt;
        w_store_we  = 1'b0;
        w_step_done = 1'b0;
        w_ctl       = '0;

        case (r_state)
            ST_LOAD: begin
                if (start) begin
                    if (r_total < CW'(MAX_REQUESTS)) begin
                        w_store_we = 1'b1;
                        n_total    = r_total + CW'(1);
                    end
                    if (i_last_request) begin
                        n_i     = '0;
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_cur_id = w_rd_data;
                if (w_hit) begin
                    w_step_done = 1'b1;
                end else if (!w_full) begin
                    w_ctl.fill  = 1'b1;
                    w_step_done = 1'b1;
                end else begin
                    w_ctl.scan_start = 1'b1;
                    n_j              = r_i + CW'(1);
                    n_scan_vld       = 1'b0;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_ctl.scan_upd = r_scan_vld;
                if (w_scan_done || (!r_scan_vld && !(r_j < r_total))) begin
                    w_ctl.evict = 1'b1;
                    n_evict     = (r_evict == CNT_MAX) ? r_evict : r_evict + CNT_W'(1);
                    w_step_done = 1'b1;
                end else begin
                    n_scan_vld = r_j < r_total;
                    n_j        = (r_j < r_total) ? r_j + CW'(1) : r_j;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        if (w_step_done) begin
            if (r_i + CW'(1) == r_total) begin
                n_out_vld   = 1'b1;
                n_out_cnt   = n_evict;
                n_total     = '0;
                n_evict     = '0;
                w_ctl.clear = 1'b1;
                n_state     = ST_LOAD;
            end else begin
                n_i     = r_i + CW'(1);
                n_state = ST_FETCH;
            end
        end
    end

    assign busy             = r_state != ST_LOAD;
    assign o_valid          = r_out_vld;
    assign o_eviction_count = r_out_cnt;

`ifndef NO_ASSERTIONS
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while replay still running");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_REQUESTS))
        else $error("request count beyond store depth");

    a_scan_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> w_full)
        else $error("victim scan with free slots");

    a_replay_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_i < r_total))
        else $error("replay index past stored sequence");
`endif

endmodule
